// ===== sv/cbc_pkg.sv =====
// Shared types, codes and bank mask tables for the cartridge bank controller.
`default_nettype none

package cbc_pkg;

    // Field widths of one bus access and one translated result
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned OFFSET_W    = 19;
    localparam int unsigned ROM_BANK_W  = 5;
    localparam int unsigned RAM_BANK_W  = 2;
    localparam int unsigned ROM_LOG_W   = 4;
    localparam int unsigned RAM_CNT_W   = 5;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT_LOG2 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT      = 1'b1;

    // Reset values of configuration and bank state
    localparam logic [ROM_LOG_W-1:0]  ROM_LOG_RESET  = 4'd1;
    localparam logic [RAM_CNT_W-1:0]  RAM_CNT_RESET  = 5'd0;
    localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 5'd1;
    localparam logic [RAM_BANK_W-1:0] RAM_BANK_RESET = 2'd0;

    // RAM enable pattern written to the low register window
    localparam logic [DATA_W-1:0] RAM_ENABLE_KEY = 8'h0A;

    // Address windows, decoded from the top address bits
    localparam logic [1:0] WIN_ROM_FIXED   = 2'b00;  // 0x0000-0x3FFF
    localparam logic [1:0] WIN_ROM_BANKED  = 2'b01;  // 0x4000-0x7FFF
    localparam logic [2:0] WIN_CART_RAM    = 3'b101; // 0xA000-0xBFFF
    localparam logic [1:0] REG_RAM_ENABLE  = 2'b00;  // 0x0000-0x1FFF
    localparam logic [1:0] REG_ROM_BANK    = 2'b01;  // 0x2000-0x3FFF
    localparam logic [1:0] REG_RAM_BANK    = 2'b10;  // 0x4000-0x5FFF

    // Where an access lands
    typedef enum logic [1:0] {
        TGT_ROM     = 2'd0,
        TGT_RAM     = 2'd1,
        TGT_REFUSED = 2'd2,
        TGT_OTHER   = 2'd3
    } t_target;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_access;

    typedef struct packed {
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  ram_enabled;
    } t_bank_state;

    typedef struct packed {
        logic [ROM_LOG_W-1:0] rom_bank_count_log2;
        logic [RAM_CNT_W-1:0] ram_bank_count;
    } t_bank_cfg;

    typedef struct packed {
        t_target             target;
        logic [OFFSET_W-1:0] physical_offset;
        logic                bank_changed;
    } t_result;

    // ROM bank mask: bank count minus one, capped at the five register bits
    function automatic logic [ROM_BANK_W-1:0] rom_mask(input logic [ROM_LOG_W-1:0] lg);
        logic [ROM_BANK_W-1:0] m;
        case (lg)
            4'd0:    m = 5'h00;
            4'd1:    m = 5'h01;
            4'd2:    m = 5'h03;
            4'd3:    m = 5'h07;
            4'd4:    m = 5'h0F;
            default: m = 5'h1F;
        endcase
        return m;
    endfunction

    // RAM bank mask: low two bits of bank count minus one, zero with no RAM fitted
    function automatic logic [RAM_BANK_W-1:0] ram_mask(input logic [RAM_CNT_W-1:0] n);
        logic [RAM_CNT_W-1:0] nm1;
        nm1 = n - 5'd1;
        return (n == '0) ? '0 : nm1[RAM_BANK_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/cartridge_bank_controller_core.sv =====
// Top level of the cartridge bank controller: input stage, bank state, result stage.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------------
//  access   | i_valid / o_ready            | i_action, i_address, i_write_data
//  result   | o_valid / i_ready            | o_target, o_physical_offset, o_bank_changed
//  config   | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One access per cycle sustained while i_ready stays high.
// The access is captured in an input register, decoded against the bank state by
// the decoder, and the result and the new bank state are loaded in the same edge.
// A stalled result holds the result register; the input register then fills and
// o_ready drops until the result is taken.
// Synchronous active-low reset: rom bank 1, ram bank 0, RAM enabled, log2 count 1.
`default_nettype none

module cartridge_bank_controller_core
    import cbc_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // access channel
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire                    i_action,
    input  wire [ADDR_W-1:0]       i_address,
    input  wire [DATA_W-1:0]       i_write_data,
    // result channel
    output logic                   o_valid,
    input  wire                    i_ready,
    output logic [1:0]             o_target,
    output logic [OFFSET_W-1:0]    o_physical_offset,
    output logic                   o_bank_changed,
    // configuration channel
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data
);

    logic        r_in_valid;
    t_access     r_in;
    logic        r_out_valid;
    t_result     r_out;
    t_bank_state r_state;
    t_bank_cfg   r_cfg;

    t_result     n_out;
    t_bank_state n_state;
    logic        advance;

    // Move an item from the input register to the result register
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // Capture each access transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in <= '{action: i_action, address: i_address, write_data: i_write_data};
        end
    end

    cbc_decode u_decode (
        .i_access     (r_in),
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .o_result     (n_out),
        .o_next_state (n_state)
    );

    // Load result and commit bank state together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{rom_bank: ROM_BANK_RESET, ram_bank: RAM_BANK_RESET,
                             ram_enabled: 1'b1};
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Configuration registers; always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{rom_bank_count_log2: ROM_LOG_RESET, ram_bank_count: RAM_CNT_RESET};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROM_BANK_COUNT_LOG2: r_cfg.rom_bank_count_log2 <= i_cfg_data[ROM_LOG_W-1:0];
                CFG_RAM_BANK_COUNT:      r_cfg.ram_bank_count      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Drive result ports
    assign o_valid           = r_out_valid;
    assign o_target          = r_out.target;
    assign o_physical_offset = r_out.physical_offset;
    assign o_bank_changed    = r_out.bank_changed;

`ifndef SYNTHESIS
    // The ROM bank register never holds bank zero
    a_rom_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.rom_bank != '0)
        else $error("rom bank register holds zero");

    // Refused and unmapped results carry no offset
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_target == TGT_REFUSED || o_target == TGT_OTHER))
        |-> o_physical_offset == '0)
        else $error("offset set on refused or unmapped result");

    // A bank change only comes from a register write
    a_change_is_reg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bank_changed) |-> o_target == TGT_OTHER)
        else $error("bank change flagged on data access");

    // RAM offsets stay inside four 8 KiB banks
    a_ram_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_target == TGT_RAM) |-> o_physical_offset[OFFSET_W-1:15] == '0)
        else $error("RAM offset out of range");

    // Bank state changes only when an item moves to the result register
    a_state_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("bank state changed without a transfer");
`endif

endmodule

`default_nettype wire

// ===== sv/cbc_decode.sv =====
// Access decoder: translates one bus access and works out the next bank state.
`default_nettype none

module cbc_decode
    import cbc_pkg::*;
(
    input  t_access     i_access,
    input  t_bank_cfg   i_cfg,
    input  t_bank_state i_state,
    output t_result     o_result,
    output t_bank_state o_next_state
);

    logic [ROM_BANK_W-1:0] rom_nb;
    logic [RAM_BANK_W-1:0] ram_nb;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_W-1:0]     data;

    assign addr = i_access.address;
    assign data = i_access.write_data;

    // Candidate bank values for register writes
    always_comb begin
        rom_nb = data[ROM_BANK_W-1:0] & rom_mask(i_cfg.rom_bank_count_log2);
        if (rom_nb == '0) begin
            rom_nb = ROM_BANK_RESET;
        end
        ram_nb = data[RAM_BANK_W-1:0] & ram_mask(i_cfg.ram_bank_count);
    end

    // Decode the access window and update the bank registers
    always_comb begin
        o_result.target          = TGT_OTHER;
        o_result.physical_offset = '0;
        o_result.bank_changed    = 1'b0;
        o_next_state             = i_state;

        if (!addr[15] && i_access.action) begin
            case (addr[14:13])
                REG_RAM_ENABLE: begin
                    o_next_state.ram_enabled = (data & RAM_ENABLE_KEY) == RAM_ENABLE_KEY;
                end
                REG_ROM_BANK: begin
                    o_result.bank_changed = rom_nb != i_state.rom_bank;
                    o_next_state.rom_bank = rom_nb;
                end
                REG_RAM_BANK: begin
                    o_result.bank_changed = ram_nb != i_state.ram_bank;
                    o_next_state.ram_bank = ram_nb;
                end
                default: begin
                    // banking mode window: accepted and ignored
                end
            endcase
        end else if (addr[15:14] == WIN_ROM_FIXED) begin
            o_result.target          = TGT_ROM;
            o_result.physical_offset = OFFSET_W'(addr);
        end else if (addr[15:14] == WIN_ROM_BANKED) begin
            if (i_cfg.rom_bank_count_log2 != '0) begin
                o_result.target          = TGT_ROM;
                o_result.physical_offset = {i_state.rom_bank, addr[13:0]};
            end
        end else if (addr[15:13] == WIN_CART_RAM) begin
            if (i_cfg.ram_bank_count != '0) begin
                if (i_state.ram_enabled) begin
                    o_result.target          = TGT_RAM;
                    o_result.physical_offset =
                        OFFSET_W'({i_state.ram_bank, addr[12:0]});
                end else begin
                    o_result.target = TGT_REFUSED;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the cartridge bank controller: directed and random bus accesses checked against a bank model.
`timescale 1ns / 1ps

module testbench;
    import cbc_pkg::*;

    localparam int unsigned IDLE_LIMIT     = 2000;
    localparam int unsigned LONG_HOLD      = 60;
    localparam int unsigned RANDOM_PER_SET = 228;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned NUM_SETS       = 8;
    localparam int unsigned MAX_REPORTS    = 10;

    // Block ports
    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  i_valid           = 1'b0;
    logic                  o_ready;
    logic                  i_action          = 1'b0;
    logic [ADDR_W-1:0]     i_address         = '0;
    logic [DATA_W-1:0]     i_write_data      = '0;
    logic                  o_valid;
    logic                  i_ready           = 1'b0;
    logic [1:0]            o_target;
    logic [OFFSET_W-1:0]   o_physical_offset;
    logic                  o_bank_changed;
    logic                  i_cfg_valid       = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data        = '0;

    // Bank model state and configuration
    logic [ROM_BANK_W-1:0] cur_rom_bank  = ROM_BANK_RESET;
    logic [RAM_BANK_W-1:0] cur_ram_bank  = RAM_BANK_RESET;
    logic                  cur_ram_on    = 1'b1;
    logic [ROM_LOG_W-1:0]  cur_rom_log   = ROM_LOG_RESET;
    logic [RAM_CNT_W-1:0]  cur_ram_count = RAM_CNT_RESET;

    t_access     pending_accesses [$];
    t_result     expected_results [$];

    logic        access_taken  = 1'b0;
    logic        result_taken  = 1'b0;
    logic        no_idle       = 1'b0;
    int unsigned send_gap      = 0;
    int unsigned sink_gap      = 0;
    int unsigned hold_left     = 0;
    int unsigned hold_step     = 0;
    int unsigned access_count  = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles   = 0;

    // Configuration settings swept by the random part; the last one is redrawn
    logic [CFG_DATA_W-1:0] rom_log_sets [NUM_SETS] = '{5'd0, 5'd9, 5'd5, 5'd15,
                                                       5'd3, 5'd2, 5'd4, 5'd1};
    logic [CFG_DATA_W-1:0] ram_cnt_sets [NUM_SETS] = '{5'd16, 5'd16, 5'd4, 5'd1,
                                                       5'd8, 5'd0, 5'd2, 5'd16};

    cartridge_bank_controller_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_action          (i_action),
        .i_address         (i_address),
        .i_write_data      (i_write_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_target          (o_target),
        .o_physical_offset (o_physical_offset),
        .o_bank_changed    (o_bank_changed),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Translate one access and advance the bank state
    function automatic t_result translate_access(input t_access acc);
        t_result               res;
        logic [ROM_BANK_W-1:0] rom_keep;
        logic [RAM_BANK_W-1:0] ram_keep;
        logic [RAM_CNT_W-1:0]  count_less;
        logic [ROM_BANK_W-1:0] next_rom;
        logic [RAM_BANK_W-1:0] next_ram;
        res.target          = TGT_OTHER;
        res.physical_offset = '0;
        res.bank_changed    = 1'b0;
        // bank masks: count minus one, rom capped at five bits, ram cut to two bits and zero with none fitted
        rom_keep   = (cur_rom_log >= 4'd5) ? 5'h1F : (5'd1 << cur_rom_log) - 5'd1;
        count_less = cur_ram_count - 5'd1;
        ram_keep   = (cur_ram_count == '0) ? '0 : count_less[RAM_BANK_W-1:0];
        if (acc.action && !acc.address[15]) begin
            // control register window
            case (acc.address[14:13])
                REG_RAM_ENABLE: begin
                    cur_ram_on = (acc.write_data & RAM_ENABLE_KEY) == RAM_ENABLE_KEY;
                end
                REG_ROM_BANK: begin
                    next_rom = acc.write_data[ROM_BANK_W-1:0] & rom_keep;
                    if (next_rom == '0) begin
                        next_rom = 5'd1;
                    end
                    res.bank_changed = (next_rom != cur_rom_bank);
                    cur_rom_bank     = next_rom;
                end
                REG_RAM_BANK: begin
                    next_ram         = acc.write_data[RAM_BANK_W-1:0] & ram_keep;
                    res.bank_changed = (next_ram != cur_ram_bank);
                    cur_ram_bank     = next_ram;
                end
                default: ;
            endcase
        end else if (acc.address[15:14] == WIN_ROM_FIXED) begin
            res.target          = TGT_ROM;
            res.physical_offset = OFFSET_W'(acc.address);
        end else if (acc.address[15:14] == WIN_ROM_BANKED) begin
            // unmapped with a single rom bank
            if (cur_rom_log != '0) begin
                res.target          = TGT_ROM;
                res.physical_offset = {cur_rom_bank, acc.address[13:0]};
            end
        end else if (acc.address[15:13] == WIN_CART_RAM) begin
            // unmapped with no ram fitted, refused while disabled
            if (cur_ram_count != '0) begin
                if (cur_ram_on) begin
                    res.target          = TGT_RAM;
                    res.physical_offset = {4'b0000, cur_ram_bank, acc.address[12:0]};
                end else begin
                    res.target = TGT_REFUSED;
                end
            end
        end
        return res;
    endfunction

    // Draw one access, weighted towards bank switching and banked windows
    function automatic t_access random_access();
        t_access     acc;
        int unsigned pick;
        pick           = $urandom_range(0, 99);
        acc.action     = 1'($urandom_range(0, 1));
        acc.address    = 16'($urandom);
        acc.write_data = 8'($urandom);
        if (pick < 25) begin
            acc.action  = 1'b1;
            acc.address = {1'b0, 15'($urandom)};
            if ($urandom_range(0, 1) == 1) begin
                acc.write_data = acc.write_data | RAM_ENABLE_KEY;
            end
        end else if (pick < 60) begin
            acc.address = 16'h4000 + 16'($urandom_range(0, 16'h3FFF));
        end else if (pick < 80) begin
            acc.address = 16'hA000 + 16'($urandom_range(0, 16'h1FFF));
        end else if (pick < 90) begin
            acc.address = 16'($urandom_range(0, 16'h3FFF));
        end
        return acc;
    endfunction

    task automatic queue_access(input logic act, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
        pending_accesses.push_back({act, addr, data});
    endtask

    // Hold until every access is issued and every result has come back
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_accesses.size() != 0 || i_valid || expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == CFG_ROM_BANK_COUNT_LOG2) begin
            cur_rom_log = value[ROM_LOG_W-1:0];
        end else begin
            cur_ram_count = value;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    // Issue accesses from the pending queue with a random gap after each transfer
    always @(negedge i_clk) begin : access_driver
        logic    next_valid;
        t_access item;
        next_valid = i_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (access_taken) begin
                next_valid = 1'b0;
                send_gap   = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (!next_valid) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (pending_accesses.size() != 0) begin
                    item         = pending_accesses.pop_front();
                    i_action     <= item.action;
                    i_address    <= item.address;
                    i_write_data <= item.write_data;
                    next_valid   = 1'b1;
                end
            end
        end
        i_valid <= next_valid;
    end

    // Stall the result side at random, with two long hold-offs to back the block up
    always @(negedge i_clk) begin : result_sink
        logic next_ready;
        next_ready = i_ready;
        if (i_rst_n) begin
            if ((hold_step == 0 && access_count >= 300) ||
                (hold_step == 1 && access_count >= 1100)) begin
                hold_left = LONG_HOLD;
                hold_step++;
            end
            if (result_taken) begin
                next_ready = 1'b0;
                sink_gap   = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (hold_left != 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (!next_ready) begin
                if (sink_gap != 0) begin
                    sink_gap--;
                end else begin
                    next_ready = 1'b1;
                end
            end
        end
        i_ready <= next_ready;
    end

    // Check each result transfer, then predict from each access transfer
    always @(posedge i_clk) begin : bus_monitor
        t_result want;
        access_taken <= i_rst_n && i_valid && o_ready;
        result_taken <= i_rst_n && o_valid && i_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: result with no access outstanding: target %0d offset %h changed %0b",
                             $time, o_target, o_physical_offset, o_bank_changed);
                end
            end else begin
                want = expected_results.pop_front();
                if (o_target !== want.target ||
                    o_physical_offset !== want.physical_offset ||
                    o_bank_changed !== want.bank_changed) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: target exp %0d got %0d, offset exp %h got %h, changed exp %0b got %0b",
                                 $time, want.target, o_target, want.physical_offset,
                                 o_physical_offset, want.bank_changed, o_bank_changed);
                    end
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            expected_results.push_back(translate_access({i_action, i_address, i_write_data}));
            access_count++;
        end
    end

    // Drop the run when no transfer has happened for too long
    always @(posedge i_clk) begin : stall_watchdog
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned           set_idx;
        int unsigned           n;
        logic [CFG_DATA_W-1:0] rom_v;
        logic [CFG_DATA_W-1:0] ram_v;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: fixed and banked rom, no ram fitted, stray windows
        queue_access(1'b0, 16'h0000, 8'hFF);
        queue_access(1'b0, 16'h4000, 8'h00);
        queue_access(1'b0, 16'h7FFF, 8'hFF);
        queue_access(1'b0, 16'hA000, 8'h00);
        queue_access(1'b0, 16'h8000, 8'hFF);
        queue_access(1'b0, 16'hFFFF, 8'h00);
        queue_access(1'b1, 16'h2000, 8'h00);
        queue_access(1'b1, 16'h3FFF, 8'hFF);
        queue_access(1'b1, 16'h4000, 8'hFF);
        queue_access(1'b1, 16'h0000, 8'h00);
        queue_access(1'b1, 16'h1FFF, 8'h0A);
        queue_access(1'b1, 16'h6000, 8'hFF);
        queue_access(1'b1, 16'hBFFF, 8'h55);
        wait_idle();

        // large bank counts: top rom bank, top ram bank, disable and re-enable ram
        write_reg(CFG_ROM_BANK_COUNT_LOG2, 5'd5);
        write_reg(CFG_RAM_BANK_COUNT, 5'd16);
        queue_access(1'b1, 16'h2000, 8'h1F);
        queue_access(1'b0, 16'h7FFF, 8'h00);
        queue_access(1'b1, 16'h5FFF, 8'hFF);
        queue_access(1'b0, 16'hBFFF, 8'h00);
        queue_access(1'b1, 16'h0000, 8'hF5);
        queue_access(1'b0, 16'hA000, 8'hFF);
        queue_access(1'b1, 16'hA123, 8'hAA);
        queue_access(1'b1, 16'h1000, 8'h0A);
        wait_idle();

        // single rom bank, and stored banks kept after the counts shrink
        write_reg(CFG_ROM_BANK_COUNT_LOG2, 5'd0);
        write_reg(CFG_RAM_BANK_COUNT, 5'd1);
        queue_access(1'b0, 16'h4000, 8'h00);
        queue_access(1'b0, 16'hA000, 8'h00);
        queue_access(1'b1, 16'h2000, 8'hFF);
        queue_access(1'b1, 16'h4000, 8'h03);
        wait_idle();

        // random accesses over a sweep of bank counts
        for (set_idx = 0; set_idx < NUM_SETS; set_idx++) begin
            rom_v = rom_log_sets[set_idx];
            ram_v = ram_cnt_sets[set_idx];
            if (set_idx == NUM_SETS - 1) begin
                rom_v = 5'($urandom_range(0, 15));
                ram_v = 5'($urandom_range(0, 16));
            end
            no_idle <= (set_idx == 2 || set_idx == 5);
            write_reg(CFG_ROM_BANK_COUNT_LOG2, rom_v);
            write_reg(CFG_RAM_BANK_COUNT, ram_v);
            for (n = 0; n < RANDOM_PER_SET; n++) begin
                pending_accesses.push_back(random_access());
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
